/* rtl/csd_pkg.sv */
package csd_pkg;

    // Parser states. Codes above ST_ERROR are never entered.
    typedef enum logic [3:0] {
        ST_TYPE  = 4'd0,
        ST_PINT  = 4'd1,
        ST_NINT  = 4'd2,
        ST_BSIZE = 4'd3,
        ST_BDATA = 4'd4,
        ST_TSIZE = 4'd5,
        ST_TDATA = 4'd6,
        ST_ARRAY = 4'd7,
        ST_MAP   = 4'd8,
        ST_TAG   = 4'd9,
        ST_FLOAT = 4'd10,
        ST_ERROR = 4'd11
    } t_state;

    // Event kinds reported with each result word.
    typedef enum logic [3:0] {
        EV_INT    = 4'd0,
        EV_EXTINT = 4'd1,
        EV_BYTES  = 4'd2,
        EV_TEXT   = 4'd3,
        EV_ARRAY  = 4'd4,
        EV_MAP    = 4'd5,
        EV_TAG    = 4'd6,
        EV_EXTTAG = 4'd7,
        EV_BOOL   = 4'd8,
        EV_NULL   = 4'd9,
        EV_UNDEF  = 4'd10,
        EV_HALF   = 4'd11,
        EV_FLOAT  = 4'd12,
        EV_DOUBLE = 4'd13,
        EV_ERROR  = 4'd14
    } t_event;

    // Error codes carried by an error event.
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_INT_INFO    = 4'd0;
    localparam logic [3:0] ERR_BYTES_INFO  = 4'd1;
    localparam logic [3:0] ERR_TEXT_INFO   = 4'd2;
    localparam logic [3:0] ERR_COUNT_INFO  = 4'd3;
    localparam logic [3:0] ERR_TAG_INFO    = 4'd4;
    localparam logic [3:0] ERR_SIMPLE      = 4'd5;
    localparam logic [3:0] ERR_SPECIAL     = 4'd6;
    localparam logic [3:0] ERR_BYTES_WIDE  = 4'd7;
    localparam logic [3:0] ERR_TEXT_WIDE   = 4'd8;
    localparam logic [3:0] ERR_ARRAY_WIDE  = 4'd9;
    localparam logic [3:0] ERR_MAP_WIDE    = 4'd10;

    // Major types.
    localparam logic [2:0] MAJ_UINT    = 3'd0;
    localparam logic [2:0] MAJ_NINT    = 3'd1;
    localparam logic [2:0] MAJ_BYTES   = 3'd2;
    localparam logic [2:0] MAJ_TEXT    = 3'd3;
    localparam logic [2:0] MAJ_ARRAY   = 3'd4;
    localparam logic [2:0] MAJ_MAP     = 3'd5;
    localparam logic [2:0] MAJ_TAG     = 3'd6;
    localparam logic [2:0] MAJ_SPECIAL = 3'd7;

    // Additional info codes.
    localparam logic [4:0] INFO_FALSE    = 5'd20;
    localparam logic [4:0] INFO_TRUE     = 5'd21;
    localparam logic [4:0] INFO_NULL     = 5'd22;
    localparam logic [4:0] INFO_UNDEF    = 5'd23;
    localparam logic [4:0] INFO_ARG1     = 5'd24;
    localparam logic [4:0] INFO_RESERVED = 5'd28;

    localparam logic [3:0]  ARG_WIDE    = 4'd8;
    localparam logic [3:0]  ARG_HALF    = 4'd2;
    localparam logic [3:0]  ARG_SINGLE  = 4'd4;
    localparam logic [63:0] INT32_LIMIT = 64'h0000_0000_7FFF_FFFF;

    typedef struct packed {
        t_event      event_res;
        logic [63:0] value;
        logic        negative;
        logic        last;
        logic        empty_res;
        logic [3:0]  error_code;
    } t_result;

endpackage

/* rtl/cbor_stream_decoder_core.sv */
// Streaming CBOR item decoder. One encoded byte enters per word on the slave
// side, and the block sustains one byte per clock cycle with no gaps while the
// consumer does not stall it. A byte sits in an input register while the parser
// classifies it and updates its state, and its result, if any, is then loaded
// into the output register. The input register drains whenever the output
// register is empty or being read, so a stalled consumer stops the input only
// once both registers are full. Integer, count, tag, simple and floating-point
// items produce one result word when their last argument byte arrives, or at
// their initial byte when they have none; argument bytes themselves produce
// nothing. String payload bytes produce one word each, with tlast on the final
// byte, and an empty string produces a single word flagged empty. Integers that
// fit in 32 bits signed and whose argument is not 8 bytes wide come out as
// sign-extended values; the others come out as a magnitude with a sign bit,
// where a negative 8-byte argument of all ones gives magnitude zero, standing
// for two to the 64th. The first error is reported once, after which the
// decoder swallows every byte silently until reset.
module cbor_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] value, [64] negative,
                                        // [68:65] error_code, [71:69] zero
    output logic        m_axis_tlast,
    output logic [4:0]  m_axis_tuser    // [3:0] event_res, [4] empty_res
);
    import csd_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       advance;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    // The parser moves whenever a byte is held and its result has a place.
    assign advance = in_valid && (!m_axis_tvalid || m_axis_tready);

    csd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .i_tdata   (s_axis_tdata),
        .o_tready  (s_axis_tready),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    csd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    csd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_tready    (m_axis_tready),
        .o_tvalid    (m_axis_tvalid),
        .o_res       (out_res)
    );

    assign m_axis_tdata = {3'd0, out_res.error_code, out_res.negative, out_res.value};
    assign m_axis_tlast = out_res.last;
    assign m_axis_tuser = {out_res.empty_res, out_res.event_res};

`ifndef SYNTHESIS
    // Only string payload words may come out without tlast.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            (out_res.event_res == EV_BYTES || out_res.event_res == EV_TEXT))
        else $error("tlast low on a non-string word");

    // Error codes are zero outside error words.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_res.event_res != EV_ERROR |->
            out_res.error_code == ERR_NONE)
        else $error("error code set on a non-error word");

    // An empty string is a single word that closes the string.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_res.empty_res |->
            m_axis_tlast && out_res.value == 64'd0 &&
            (out_res.event_res == EV_BYTES || out_res.event_res == EV_TEXT))
        else $error("malformed empty string word");

    // Errors stick: once an error word is taken nothing follows it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && out_res.event_res == EV_ERROR |=>
            !m_axis_tvalid)
        else $error("result word after an error");

    // Only the large integer form carries a sign bit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_res.negative |-> out_res.event_res == EV_EXTINT)
        else $error("sign bit on a non-extended word");
`endif
endmodule

/* rtl/csd_in_reg.sv */
module csd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tvalid,
    input  logic [7:0] i_tdata,
    output logic       o_tready,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;

    // The held byte leaves in the same cycle that a new one may enter.
    assign o_tready = !r_valid || i_advance;
    assign n_valid  = (r_valid && !i_advance) || (i_tvalid && o_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_byte <= i_tdata;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

/* rtl/csd_parse.sv */
module csd_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output csd_pkg::t_result o_res
);
    import csd_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic [3:0]  r_left;
    logic [3:0]  n_left;
    logic [3:0]  r_width;
    logic [3:0]  n_width;
    logic [63:0] r_acc;
    logic [63:0] n_acc;
    logic [31:0] r_payload;
    logic [31:0] n_payload;

    logic [2:0]  major;
    logic [4:0]  info;
    logic [63:0] acc_shift;
    logic [3:0]  left_dec;
    logic        arg_done;
    logic        wide;
    logic        fits_int;
    logic [31:0] payload_dec;
    logic [3:0]  type_width;

    assign major       = i_byte[7:5];
    assign info        = i_byte[4:0];
    assign acc_shift   = {r_acc[55:0], i_byte};
    assign left_dec    = (r_left != 4'd0) ? r_left - 4'd1 : 4'd0;
    assign arg_done    = (left_dec == 4'd0);
    assign wide        = (r_width == ARG_WIDE);
    assign fits_int    = !wide && (acc_shift <= INT32_LIMIT);
    assign payload_dec = (r_payload != 32'd0) ? r_payload - 32'd1 : 32'd0;

    always_comb begin
        case (info[1:0])
            2'd0:    type_width = 4'd1;
            2'd1:    type_width = 4'd2;
            2'd2:    type_width = 4'd4;
            default: type_width = 4'd8;
        endcase
    end

    // Result word for the byte in the input register.
    always_comb begin
        o_res_valid      = 1'b0;
        o_res.event_res  = EV_INT;
        o_res.value      = 64'd0;
        o_res.negative   = 1'b0;
        o_res.last       = 1'b1;
        o_res.empty_res  = 1'b0;
        o_res.error_code = ERR_NONE;
        case (r_state)
            ST_TYPE: begin
                if (major == MAJ_SPECIAL) begin
                    if (info < INFO_FALSE) begin
                        o_res_valid      = 1'b1;
                        o_res.event_res  = EV_ERROR;
                        o_res.error_code = ERR_SIMPLE;
                    end else if (info == INFO_FALSE || info == INFO_TRUE) begin
                        o_res_valid     = 1'b1;
                        o_res.event_res = EV_BOOL;
                        o_res.value     = {63'd0, info == INFO_TRUE};
                    end else if (info == INFO_NULL) begin
                        o_res_valid     = 1'b1;
                        o_res.event_res = EV_NULL;
                    end else if (info == INFO_UNDEF) begin
                        o_res_valid     = 1'b1;
                        o_res.event_res = EV_UNDEF;
                    end else if (info >= INFO_RESERVED) begin
                        o_res_valid      = 1'b1;
                        o_res.event_res  = EV_ERROR;
                        o_res.error_code = ERR_SPECIAL;
                    end
                end else if (info < INFO_ARG1) begin
                    o_res.value = {59'd0, info};
                    case (major)
                        MAJ_UINT: begin
                            o_res_valid     = 1'b1;
                            o_res.event_res = EV_INT;
                        end
                        MAJ_NINT: begin
                            o_res_valid     = 1'b1;
                            o_res.event_res = EV_INT;
                            o_res.value     = ~{59'd0, info};
                        end
                        MAJ_BYTES: begin
                            o_res_valid     = (info == 5'd0);
                            o_res.event_res = EV_BYTES;
                            o_res.empty_res = 1'b1;
                        end
                        MAJ_TEXT: begin
                            o_res_valid     = (info == 5'd0);
                            o_res.event_res = EV_TEXT;
                            o_res.empty_res = 1'b1;
                        end
                        MAJ_ARRAY: begin
                            o_res_valid     = 1'b1;
                            o_res.event_res = EV_ARRAY;
                        end
                        MAJ_MAP: begin
                            o_res_valid     = 1'b1;
                            o_res.event_res = EV_MAP;
                        end
                        default: begin
                            o_res_valid     = 1'b1;
                            o_res.event_res = EV_TAG;
                        end
                    endcase
                end else if (info >= INFO_RESERVED) begin
                    o_res_valid     = 1'b1;
                    o_res.event_res = EV_ERROR;
                    case (major)
                        MAJ_BYTES: o_res.error_code = ERR_BYTES_INFO;
                        MAJ_TEXT:  o_res.error_code = ERR_TEXT_INFO;
                        MAJ_ARRAY: o_res.error_code = ERR_COUNT_INFO;
                        MAJ_MAP:   o_res.error_code = ERR_COUNT_INFO;
                        MAJ_TAG:   o_res.error_code = ERR_TAG_INFO;
                        default:   o_res.error_code = ERR_INT_INFO;
                    endcase
                end
            end
            ST_PINT, ST_NINT, ST_BSIZE, ST_TSIZE, ST_ARRAY, ST_MAP, ST_TAG,
            ST_FLOAT: begin
                if (arg_done) begin
                    o_res_valid = 1'b1;
                    o_res.value = acc_shift;
                    case (r_state)
                        ST_PINT: begin
                            o_res.event_res = fits_int ? EV_INT : EV_EXTINT;
                        end
                        ST_NINT: begin
                            if (fits_int) begin
                                o_res.event_res = EV_INT;
                                o_res.value     = ~acc_shift;
                            end else begin
                                o_res.event_res = EV_EXTINT;
                                o_res.value     = acc_shift + 64'd1;
                                o_res.negative  = 1'b1;
                            end
                        end
                        ST_BSIZE, ST_TSIZE: begin
                            if (wide) begin
                                o_res.event_res  = EV_ERROR;
                                o_res.value      = 64'd0;
                                o_res.error_code = (r_state == ST_BSIZE) ?
                                                   ERR_BYTES_WIDE : ERR_TEXT_WIDE;
                            end else begin
                                // Only an empty string reports at its header.
                                o_res_valid     = (acc_shift[31:0] == 32'd0);
                                o_res.event_res = (r_state == ST_BSIZE) ?
                                                  EV_BYTES : EV_TEXT;
                                o_res.value     = 64'd0;
                                o_res.empty_res = 1'b1;
                            end
                        end
                        ST_ARRAY, ST_MAP: begin
                            if (wide) begin
                                o_res.event_res  = EV_ERROR;
                                o_res.value      = 64'd0;
                                o_res.error_code = (r_state == ST_ARRAY) ?
                                                   ERR_ARRAY_WIDE : ERR_MAP_WIDE;
                            end else begin
                                o_res.event_res = (r_state == ST_ARRAY) ?
                                                  EV_ARRAY : EV_MAP;
                            end
                        end
                        ST_TAG: begin
                            o_res.event_res = wide ? EV_EXTTAG : EV_TAG;
                        end
                        default: begin
                            if (r_width == ARG_HALF) begin
                                o_res.event_res = EV_HALF;
                            end else if (r_width == ARG_SINGLE) begin
                                o_res.event_res = EV_FLOAT;
                            end else begin
                                o_res.event_res = EV_DOUBLE;
                            end
                        end
                    endcase
                end
            end
            ST_BDATA, ST_TDATA: begin
                o_res_valid     = 1'b1;
                o_res.event_res = (r_state == ST_TDATA) ? EV_TEXT : EV_BYTES;
                o_res.value     = {56'd0, i_byte};
                o_res.last      = (payload_dec == 32'd0);
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    // Next parser state.
    always_comb begin
        n_state   = r_state;
        n_left    = r_left;
        n_width   = r_width;
        n_acc     = r_acc;
        n_payload = r_payload;
        case (r_state)
            ST_TYPE: begin
                if (major == MAJ_SPECIAL && info < INFO_FALSE) begin
                    n_state = ST_ERROR;
                end else if (major != MAJ_SPECIAL && info < INFO_ARG1) begin
                    if (major == MAJ_BYTES && info != 5'd0) begin
                        n_payload = {27'd0, info};
                        n_state   = ST_BDATA;
                    end else if (major == MAJ_TEXT && info != 5'd0) begin
                        n_payload = {27'd0, info};
                        n_state   = ST_TDATA;
                    end
                end else if (info >= INFO_RESERVED) begin
                    n_state = ST_ERROR;
                end else if (info >= INFO_ARG1) begin
                    n_width = type_width;
                    n_left  = type_width;
                    n_acc   = 64'd0;
                    case (major)
                        MAJ_UINT:  n_state = ST_PINT;
                        MAJ_NINT:  n_state = ST_NINT;
                        MAJ_BYTES: n_state = ST_BSIZE;
                        MAJ_TEXT:  n_state = ST_TSIZE;
                        MAJ_ARRAY: n_state = ST_ARRAY;
                        MAJ_MAP:   n_state = ST_MAP;
                        MAJ_TAG:   n_state = ST_TAG;
                        default:   n_state = (info == INFO_ARG1) ? ST_PINT : ST_FLOAT;
                    endcase
                end
            end
            ST_PINT, ST_NINT, ST_BSIZE, ST_TSIZE, ST_ARRAY, ST_MAP, ST_TAG,
            ST_FLOAT: begin
                n_acc  = acc_shift;
                n_left = left_dec;
                if (arg_done) begin
                    n_state = ST_TYPE;
                    if (r_state == ST_BSIZE || r_state == ST_TSIZE) begin
                        if (wide) begin
                            n_state = ST_ERROR;
                        end else if (acc_shift[31:0] != 32'd0) begin
                            n_payload = acc_shift[31:0];
                            n_state   = (r_state == ST_BSIZE) ? ST_BDATA : ST_TDATA;
                        end
                    end else if ((r_state == ST_ARRAY || r_state == ST_MAP) && wide) begin
                        n_state = ST_ERROR;
                    end
                end
            end
            ST_BDATA, ST_TDATA: begin
                n_payload = payload_dec;
                if (payload_dec == 32'd0) begin
                    n_state = ST_TYPE;
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_TYPE;
            r_left    <= 4'd0;
            r_width   <= 4'd0;
            r_acc     <= 64'd0;
            r_payload <= 32'd0;
        end else if (i_fire) begin
            r_state   <= n_state;
            r_left    <= n_left;
            r_width   <= n_width;
            r_acc     <= n_acc;
            r_payload <= n_payload;
        end
    end
endmodule

/* rtl/csd_out_reg.sv */
module csd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_res_valid,
    input  csd_pkg::t_result i_res,
    input  logic             i_tready,
    output logic             o_tvalid,
    output csd_pkg::t_result o_res
);
    import csd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // A load only happens when the register is empty or being drained.
    always_comb begin
        if (i_load) begin
            n_valid = i_res_valid;
        end else if (i_tready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_res    = r_res;
endmodule
